// ----- rtl/gpio_pkg.sv -----
// gpio_pkg: request codes, register map, bank request and status bundles
// and the result record shared by the bank and the top level
// depends on nothing
package gpio_pkg;

  localparam int unsigned BANK_STRIDE = 32;
  localparam int unsigned PAD_COUNT   = 64;

  // request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register map of one bank
  localparam logic [4:0] REG_DIR   = 5'd0;
  localparam logic [4:0] REG_DOR   = 5'd1;
  localparam logic [4:0] REG_DOSR  = 5'd2;
  localparam logic [4:0] REG_DOCR  = 5'd3;
  localparam logic [4:0] REG_DOER  = 5'd4;
  localparam logic [4:0] REG_DOESR = 5'd5;
  localparam logic [4:0] REG_DOECR = 5'd6;
  localparam logic [4:0] REG_IER   = 5'd7;
  localparam logic [4:0] REG_IESR  = 5'd8;
  localparam logic [4:0] REG_IECR  = 5'd9;
  localparam logic [4:0] REG_ITR   = 5'd10;
  localparam logic [4:0] REG_ITSR  = 5'd11;
  localparam logic [4:0] REG_ITCR  = 5'd12;
  localparam logic [4:0] REG_IPHR  = 5'd13;
  localparam logic [4:0] REG_IPHSR = 5'd14;
  localparam logic [4:0] REG_IPHCR = 5'd15;
  localparam logic [4:0] REG_IPLR  = 5'd16;
  localparam logic [4:0] REG_IPLSR = 5'd17;
  localparam logic [4:0] REG_IPLCR = 5'd18;
  localparam logic [4:0] REG_ISR   = 5'd19;

  // one accepted item as seen by a bank
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        tick;
    logic [4:0]  sel;
    logic [31:0] wdata;
    logic [31:0] levels;
  } gpio_req_t;

  // bank state after the item, zero-extended to the bank stride
  typedef struct packed {
    logic [31:0] rdata;
    logic [31:0] act;
    logic [31:0] drive;
    logic [31:0] enable;
  } gpio_bank_st_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic        any;
    logic [5:0]  lowest;
    logic [63:0] drive;
    logic [63:0] enable;
  } gpio_res_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [4:0] lowest_bit(logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/gpio_bank.sv -----
// gpio_bank: register file of one pin bank with set/clear aliases,
// write-1-clear pending bits and edge or level interrupt latching
// depends on gpio_pkg
module gpio_bank
  import gpio_pkg::*;
#(
  parameter int unsigned PINS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gpio_req_t     req,
  output gpio_bank_st_t st
);

  logic [PINS-1:0] smp_r,   smp_nxt;
  logic [PINS-1:0] latch_r, latch_nxt;
  logic [PINS-1:0] oe_r,    oe_nxt;
  logic [PINS-1:0] ie_r,    ie_nxt;
  logic [PINS-1:0] trig_r,  trig_nxt;
  logic [PINS-1:0] phi_r,   phi_nxt;
  logic [PINS-1:0] plo_r,   plo_nxt;
  logic [PINS-1:0] pend_r,  pend_nxt;

  logic [PINS-1:0] wd;
  logic [PINS-1:0] now;
  logic [PINS-1:0] rise;
  logic [PINS-1:0] fall;
  logic [PINS-1:0] edge_hit;
  logic [PINS-1:0] level_hit;
  logic [PINS-1:0] rd_val;

  assign wd  = req.wdata[PINS-1:0];
  assign now = req.levels[PINS-1:0];

  assign rise      = now & ~smp_r;
  assign fall      = ~now & smp_r;
  assign edge_hit  = trig_r & ((phi_r & rise) | (plo_r & fall));
  assign level_hit = ~trig_r & ((phi_r & now) | (plo_r & ~now));

  always_comb begin
    smp_nxt   = smp_r;
    latch_nxt = latch_r;
    oe_nxt    = oe_r;
    ie_nxt    = ie_r;
    trig_nxt  = trig_r;
    phi_nxt   = phi_r;
    plo_nxt   = plo_r;
    pend_nxt  = pend_r;
    if (req.wr) begin
      case (req.sel)
        REG_DOR:   latch_nxt = wd;
        REG_DOSR:  latch_nxt = latch_r | wd;
        REG_DOCR:  latch_nxt = latch_r & ~wd;
        REG_DOER:  oe_nxt    = wd;
        REG_DOESR: oe_nxt    = oe_r | wd;
        REG_DOECR: oe_nxt    = oe_r & ~wd;
        REG_IER:   ie_nxt    = wd;
        REG_IESR:  ie_nxt    = ie_r | wd;
        REG_IECR:  ie_nxt    = ie_r & ~wd;
        REG_ITR:   trig_nxt  = wd;
        REG_ITSR:  trig_nxt  = trig_r | wd;
        REG_ITCR:  trig_nxt  = trig_r & ~wd;
        REG_IPHR:  phi_nxt   = wd;
        REG_IPHSR: phi_nxt   = phi_r | wd;
        REG_IPHCR: phi_nxt   = phi_r & ~wd;
        REG_IPLR:  plo_nxt   = wd;
        REG_IPLSR: plo_nxt   = plo_r | wd;
        REG_IPLCR: plo_nxt   = plo_r & ~wd;
        REG_ISR:   pend_nxt  = pend_r & ~wd;
        default: begin
          // input level and unmapped codes ignore writes
        end
      endcase
    end
    if (req.tick) begin
      smp_nxt  = now;
      pend_nxt = pend_r | edge_hit | level_hit;
    end
  end

  // reads change nothing, so current contents are the state after the item
  always_comb begin
    case (req.sel)
      REG_DIR:                        rd_val = (oe_r & latch_r) | (~oe_r & smp_r);
      REG_DOR, REG_DOSR, REG_DOCR:    rd_val = latch_r;
      REG_DOER, REG_DOESR, REG_DOECR: rd_val = oe_r;
      REG_IER, REG_IESR, REG_IECR:    rd_val = ie_r;
      REG_ITR, REG_ITSR, REG_ITCR:    rd_val = trig_r;
      REG_IPHR, REG_IPHSR, REG_IPHCR: rd_val = phi_r;
      REG_IPLR, REG_IPLSR, REG_IPLCR: rd_val = plo_r;
      REG_ISR:                        rd_val = pend_r;
      default:                        rd_val = '0;
    endcase
  end

  assign st.rdata  = req.rd ? 32'(rd_val) : '0;
  assign st.act    = 32'(pend_nxt & ie_nxt);
  assign st.drive  = 32'(latch_nxt);
  assign st.enable = 32'(oe_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r   <= '0;
      latch_r <= '0;
      oe_r    <= '0;
      ie_r    <= '0;
      trig_r  <= '0;
      phi_r   <= '0;
      plo_r   <= '0;
      pend_r  <= '0;
    end else begin
      smp_r   <= smp_nxt;
      latch_r <= latch_nxt;
      oe_r    <= oe_nxt;
      ie_r    <= ie_nxt;
      trig_r  <= trig_nxt;
      phi_r   <= phi_nxt;
      plo_r   <= plo_nxt;
      pend_r  <= pend_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // pending bits only appear on a sample tick
  a_pend_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !req.tick |=> ((pend_r & ~$past(pend_r)) == '0))
    else $error("pending bit set without a sample tick");

  // the sampled level only moves on a tick
  a_smp_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !req.tick |=> $stable(smp_r))
    else $error("input sample changed without a tick");

  // configuration registers only move on a write
  a_cfg_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !req.wr |=> ($stable(latch_r) && $stable(oe_r) && $stable(ie_r) && $stable(trig_r)))
    else $error("register changed without a write");
`endif

endmodule

// ----- rtl/gpio_port_with_edge_interrupts_unit.sv -----
// gpio_port_with_edge_interrupts_unit: top level of the two-bank gpio port,
// bank registers, lowest-pending-pin encoder and output skid stage
// depends on gpio_pkg and gpio_bank
//
//  channel  handshake           payload
//  in       in_valid/in_stall   req_type, bank, reg_sel, wdata, pin_levels
//  out      out_valid/out_stall rdata, irq_out, pending_any, lowest_pending_pin,
//                               pad_drive, pad_enable
//
// one item per cycle while in_stall is low; the result is registered in the output register,
// or first in the skid register while the output is held; bank state updates at the
// accepting edge, results show the state after it; a skid register holds one extra result,
// so in_stall rises only when both the output and skid registers are full
// rst_n is synchronous; bank registers, pending bits and valid flags clear to zero, result data is not reset
module gpio_port_with_edge_interrupts_unit
  import gpio_pkg::*;
#(
  parameter int unsigned PINS_PER_BANK = 32,
  parameter int unsigned BANK_COUNT    = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic        in_bank,
  input  logic [4:0]  in_reg_sel,
  input  logic [31:0] in_wdata,
  input  logic [63:0] in_pin_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rdata,
  output logic        out_irq_out,
  output logic        out_pending_any,
  output logic [5:0]  out_lowest_pending_pin,
  output logic [63:0] out_pad_drive,
  output logic [63:0] out_pad_enable
);

  logic          in_acc;
  logic          out_take;
  gpio_bank_st_t bank_st [2];
  gpio_res_t     res;

  logic          out_vld_r,  out_vld_nxt;
  gpio_res_t     out_res_r,  out_res_nxt;
  logic          skid_vld_r, skid_vld_nxt;
  gpio_res_t     skid_res_r, skid_res_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_vld_r && !out_stall;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    if (b < BANK_COUNT) begin : g_on
      gpio_req_t req;
      assign req.rd     = in_acc && (in_req_type == REQ_READ) && (in_bank == 1'(b));
      assign req.wr     = in_acc && (in_req_type == REQ_WRITE) && (in_bank == 1'(b));
      assign req.tick   = in_acc && (in_req_type == REQ_TICK);
      assign req.sel    = in_reg_sel;
      assign req.wdata  = in_wdata;
      assign req.levels = in_pin_levels[b*BANK_STRIDE +: BANK_STRIDE];

      gpio_bank #(
        .PINS (PINS_PER_BANK)
      ) u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .st    (bank_st[b])
      );
    end else begin : g_off
      // missing bank reads zero and drives zeros
      assign bank_st[b] = '0;
    end
  end

  always_comb begin
    res.rdata  = bank_st[0].rdata | bank_st[1].rdata;
    res.irq    = (bank_st[0].act != '0) || (bank_st[1].act != '0);
    res.any    = res.irq;
    res.drive  = {bank_st[1].drive, bank_st[0].drive};
    res.enable = {bank_st[1].enable, bank_st[0].enable};
    // bank 0 wins
    if (bank_st[0].act != '0) begin
      res.lowest = {1'b0, lowest_bit(bank_st[0].act)};
    end else if (bank_st[1].act != '0) begin
      res.lowest = {1'b1, lowest_bit(bank_st[1].act)};
    end else begin
      res.lowest = '0;
    end
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (out_take || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = in_acc;
        out_res_nxt = res;
      end
    end else if (in_acc) begin
      // output held, park the new item
      skid_vld_nxt = 1'b1;
      skid_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign in_stall               = skid_vld_r;
  assign out_valid              = out_vld_r;
  assign out_rdata              = out_res_r.rdata;
  assign out_irq_out            = out_res_r.irq;
  assign out_pending_any        = out_res_r.any;
  assign out_lowest_pending_pin = out_res_r.lowest;
  assign out_pad_drive          = out_res_r.drive;
  assign out_pad_enable         = out_res_r.enable;

`ifndef NO_ASSERTIONS
  // the skid register only holds an item behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  // the skid register fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid register filled without an output stall");

  // interrupt line and pending flag agree
  a_irq_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.irq == out_res_r.any))
    else $error("irq_out and pending_any disagree");

  // no pending pin reports pin zero
  a_lowest_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res_r.any) |-> (out_res_r.lowest == '0))
    else $error("lowest pending pin nonzero with nothing pending");
`endif

endmodule

// ----- tb/gpio_port_with_edge_interrupts_unit_tb.sv -----
// gpio_port_with_edge_interrupts_unit_tb: self-checking bench for the two-bank gpio port
// drives a directed table and then random register and pad-sample traffic, and checks every
// result against pinned values or an in-bench model of the bank registers; depends on gpio_pkg
`timescale 1ns / 100ps

module gpio_port_with_edge_interrupts_unit_tb;
  import gpio_pkg::*;

  localparam logic [1:0] REQ_NONE      = 2'd3;
  localparam logic [4:0] REG_UNUSED_LO = 5'd20;
  localparam logic [4:0] REG_UNUSED_HI = 5'd31;
  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_ITEMS   = 50;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_LEN     = 80;
  localparam int PAUSE_AT     = 260;
  localparam int IDLE_LIMIT   = 2000;

  typedef struct packed {
    logic [1:0]  req;
    logic        bank;
    logic [4:0]  sel;
    logic [31:0] wdata;
    logic [63:0] levels;
  } bus_item_t;

  typedef struct packed {
    bus_item_t item;
    logic      typed;
    gpio_res_t exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic        in_bank = 1'b0;
  logic [4:0]  in_reg_sel = '0;
  logic [31:0] in_wdata = '0;
  logic [63:0] in_pin_levels = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_rdata;
  logic        out_irq_out;
  logic        out_pending_any;
  logic [5:0]  out_lowest_pending_pin;
  logic [63:0] out_pad_drive;
  logic [63:0] out_pad_enable;

  gpio_port_with_edge_interrupts_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_bank               (in_bank),
    .in_reg_sel            (in_reg_sel),
    .in_wdata              (in_wdata),
    .in_pin_levels         (in_pin_levels),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rdata             (out_rdata),
    .out_irq_out           (out_irq_out),
    .out_pending_any       (out_pending_any),
    .out_lowest_pending_pin(out_lowest_pending_pin),
    .out_pad_drive         (out_pad_drive),
    .out_pad_enable        (out_pad_enable)
  );

  always #4 clk = ~clk;

  // model of the bank registers, indexed by bank
  logic [31:0] pad_sample [2];
  logic [31:0] pad_prev [2];
  logic [31:0] drive_latch [2];
  logic [31:0] drive_en [2];
  logic [31:0] irq_en [2];
  logic [31:0] edge_mode [2];
  logic [31:0] pol_hi [2];
  logic [31:0] pol_lo [2];
  logic [31:0] pend [2];

  stim_row_t stim_q[$];
  gpio_res_t port_status_q[$];
  stim_row_t cur_row;

  int next_idx = 0;
  int sent_cnt = 0;
  int gap_cnt = 0;
  bit pause_done = 1'b0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  int stall_cnt = 0;
  int idle_cycles = 0;
  int err_cnt = 0;
  int checked_cnt = 0;
  int irq_seen = 0;
  int n_read = 0;
  int n_write = 0;
  int n_tick = 0;

  // base, set or clear alias applied to one register
  function automatic logic [31:0] aliased(logic [31:0] cur, logic [4:0] offs, logic [31:0] d);
    if (offs == 5'd0) return d;
    else if (offs == 5'd1) return cur | d;
    else return cur & ~d;
  endfunction

  // applies one item to the model and returns the port status after it
  function automatic gpio_res_t next_port_status(bus_item_t it);
    gpio_res_t r;
    logic [31:0] now, rise, fall, act;
    int b;
    r = '0;
    b = it.bank;
    case (it.req)
      REQ_READ: begin
        case (it.sel)
          REG_DIR: r.rdata = (drive_en[b] & drive_latch[b]) | (~drive_en[b] & pad_sample[b]);
          REG_DOR, REG_DOSR, REG_DOCR: r.rdata = drive_latch[b];
          REG_DOER, REG_DOESR, REG_DOECR: r.rdata = drive_en[b];
          REG_IER, REG_IESR, REG_IECR: r.rdata = irq_en[b];
          REG_ITR, REG_ITSR, REG_ITCR: r.rdata = edge_mode[b];
          REG_IPHR, REG_IPHSR, REG_IPHCR: r.rdata = pol_hi[b];
          REG_IPLR, REG_IPLSR, REG_IPLCR: r.rdata = pol_lo[b];
          REG_ISR: r.rdata = pend[b];
          default: r.rdata = '0;
        endcase
      end
      REQ_WRITE: begin
        case (it.sel)
          REG_DOR, REG_DOSR, REG_DOCR:
            drive_latch[b] = aliased(drive_latch[b], it.sel - REG_DOR, it.wdata);
          REG_DOER, REG_DOESR, REG_DOECR:
            drive_en[b] = aliased(drive_en[b], it.sel - REG_DOER, it.wdata);
          REG_IER, REG_IESR, REG_IECR:
            irq_en[b] = aliased(irq_en[b], it.sel - REG_IER, it.wdata);
          REG_ITR, REG_ITSR, REG_ITCR:
            edge_mode[b] = aliased(edge_mode[b], it.sel - REG_ITR, it.wdata);
          REG_IPHR, REG_IPHSR, REG_IPHCR:
            pol_hi[b] = aliased(pol_hi[b], it.sel - REG_IPHR, it.wdata);
          REG_IPLR, REG_IPLSR, REG_IPLCR:
            pol_lo[b] = aliased(pol_lo[b], it.sel - REG_IPLR, it.wdata);
          REG_ISR: pend[b] = pend[b] & ~it.wdata;
          default: ;
        endcase
      end
      REQ_TICK: begin
        for (int k = 0; k < 2; k++) begin
          now = it.levels[k*32 +: 32];
          rise = now & ~pad_sample[k];
          fall = ~now & pad_sample[k];
          pend[k] = pend[k]
                  | (edge_mode[k] & ((pol_hi[k] & rise) | (pol_lo[k] & fall)))
                  | (~edge_mode[k] & ((pol_hi[k] & now) | (pol_lo[k] & ~now)));
          pad_prev[k] = pad_sample[k];
          pad_sample[k] = now;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < 2; k++) begin
      r.drive[k*32 +: 32] = drive_latch[k];
      r.enable[k*32 +: 32] = drive_en[k];
      act = pend[k] & irq_en[k];
      if (act != 0) begin
        r.irq = 1'b1;
        if (!r.any) begin
          r.any = 1'b1;
          for (int i = 31; i >= 0; i--) begin
            if (act[i]) r.lowest = 6'(k*32 + i);
          end
        end
      end
    end
    return r;
  endfunction

  task automatic add_item(input logic [1:0] req, input logic b, input logic [4:0] sel,
                          input logic [31:0] wd, input logic [63:0] lv);
    stim_row_t row;
    row = '0;
    row.item = '{req: req, bank: b, sel: sel, wdata: wd, levels: lv};
    stim_q.push_back(row);
  endtask

  // fixes the expected status of the row just added
  task automatic pin_last_result(input gpio_res_t e);
    stim_row_t row;
    row = stim_q.pop_back();
    row.typed = 1'b1;
    row.exp = e;
    stim_q.push_back(row);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic build_stimulus();
    gpio_res_t e;
    logic [63:0] lv;
    logic b;
    int steps;
    e = '0;
    // all-zero status straight out of reset, also for unknown selects and request codes
    add_item(REQ_READ, 1'b0, REG_DIR, 32'hffff_ffff, '1);
    pin_last_result(e);
    add_item(REQ_READ, 1'b1, REG_ISR, 32'h0, '0);
    pin_last_result(e);
    add_item(REQ_READ, 1'b0, REG_UNUSED_HI, 32'h0, '0);
    pin_last_result(e);
    add_item(REQ_NONE, 1'b1, REG_UNUSED_HI, 32'hffff_ffff, '1);
    pin_last_result(e);
    add_item(REQ_WRITE, 1'b0, REG_DOR, 32'hffff_ffff, '0);
    e.drive = 64'h0000_0000_ffff_ffff;
    pin_last_result(e);
    add_item(REQ_WRITE, 1'b1, REG_DOER, 32'hffff_ffff, '0);
    e.enable = 64'hffff_ffff_0000_0000;
    pin_last_result(e);
    add_item(REQ_WRITE, 1'b1, REG_DOSR, 32'h8000_0001, '0);
    add_item(REQ_WRITE, 1'b0, REG_DOCR, 32'h0000_ffff, '0);
    add_item(REQ_WRITE, 1'b0, REG_DOESR, 32'ha5a5_a5a5, '0);
    add_item(REQ_WRITE, 1'b1, REG_DOECR, 32'h0f0f_0f0f, '0);
    add_item(REQ_WRITE, 1'b0, REG_DIR, 32'hffff_ffff, '0);
    add_item(REQ_WRITE, 1'b1, REG_UNUSED_LO, 32'hffff_ffff, '0);
    add_item(REQ_TICK, 1'b0, REG_DIR, 32'h0, '1);
    add_item(REQ_READ, 1'b0, REG_DIR, 32'h0, '0);
    add_item(REQ_WRITE, 1'b0, REG_IER, 32'hffff_ffff, '0);
    add_item(REQ_WRITE, 1'b0, REG_IPHR, 32'h0000_ffff, '0);
    // bank 1 latches low levels with no interrupt enabled
    add_item(REQ_WRITE, 1'b1, REG_IPLR, 32'hffff_ffff, '0);
    add_item(REQ_TICK, 1'b1, REG_ISR, 32'h0, 64'h0000_0000_0000_0100);
    add_item(REQ_WRITE, 1'b1, REG_ITSR, 32'hffff_ffff, '0);
    add_item(REQ_WRITE, 1'b1, REG_IPHSR, 32'h8000_0000, '0);
    add_item(REQ_WRITE, 1'b1, REG_IESR, 32'h8000_0000, '0);
    // level bit comes back on the next tick after a clear
    add_item(REQ_WRITE, 1'b0, REG_ISR, 32'hffff_ffff, '0);
    add_item(REQ_TICK, 1'b0, REG_DIR, 32'h0, 64'h8000_0000_0000_0100);
    add_item(REQ_WRITE, 1'b0, REG_IECR, 32'hffff_ffff, '0);
    add_item(REQ_WRITE, 1'b1, REG_ITCR, 32'h0000_ffff, '0);
    add_item(REQ_WRITE, 1'b0, REG_IPHCR, 32'h0000_00ff, '0);
    add_item(REQ_WRITE, 1'b0, REG_IPLSR, 32'h0000_0f00, '0);
    add_item(REQ_WRITE, 1'b1, REG_IPLCR, 32'hffff_0000, '0);
    add_item(REQ_READ, 1'b0, REG_IPHSR, 32'h0, '0);

    steps = stim_q.size() + RANDOM_ITEMS;
    lv = '0;
    while (stim_q.size() < steps) begin
      if ($urandom_range(0, 9) < 7) begin
        // configure a bank, sample a few times, then read and sometimes clear status
        b = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 4))
          add_item(REQ_WRITE, b, 5'($urandom_range(REG_DOR, REG_IPLCR)), rand_word(), $urandom);
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(0, 3) == 0) lv = {$urandom, $urandom};
          else lv = lv ^ ({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
          add_item(REQ_TICK, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), $urandom, lv);
        end
        add_item(REQ_READ, b, $urandom_range(0, 1) ? REG_ISR : REG_DIR, $urandom, $urandom);
        if ($urandom_range(0, 1))
          add_item(REQ_WRITE, b, REG_ISR, rand_word(), {$urandom, $urandom});
      end else begin
        add_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                 rand_word(), {$urandom, $urandom});
      end
    end
  endtask

  // sender: offers items from the table, with idle bursts and one pause to drain
  always @(posedge clk) begin : send_items
    gpio_res_t status;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        status = next_port_status(cur_row.item);
        port_status_q.push_back(cur_row.typed ? cur_row.exp : status);
        sent_cnt++;
        case (cur_row.item.req)
          REQ_READ: n_read++;
          REQ_WRITE: n_write++;
          REQ_TICK: n_tick++;
          default: ;
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (next_idx == PAUSE_AT && !pause_done) begin
          in_valid <= 1'b0;
          if (port_status_q.size() == 0) pause_done = 1'b1;
        end else if (next_idx < stim_q.size()) begin
          cur_row = stim_q[next_idx];
          next_idx++;
          in_valid <= 1'b1;
          in_req_type <= cur_row.item.req;
          in_bank <= cur_row.item.bank;
          in_reg_sel <= cur_row.item.sel;
          in_wdata <= cur_row.item.wdata;
          in_pin_levels <= cur_row.item.levels;
          if (next_idx < stim_q.size() - TAIL_ITEMS && $urandom_range(0, 5) == 0)
            gap_cnt = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result and drives out_stall
  always @(posedge clk) begin : check_results
    gpio_res_t seen, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.rdata = out_rdata;
        seen.irq = out_irq_out;
        seen.any = out_pending_any;
        seen.lowest = out_lowest_pending_pin;
        seen.drive = out_pad_drive;
        seen.enable = out_pad_enable;
        if (seen.irq) irq_seen++;
        if (port_status_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result at %0t: rdata %h", $realtime, seen.rdata);
        end else begin
          want = port_status_q.pop_front();
          checked_cnt++;
          if (seen.rdata !== want.rdata || seen.irq !== want.irq || seen.any !== want.any ||
              seen.lowest !== want.lowest || seen.drive !== want.drive ||
              seen.enable !== want.enable) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch on result %0d at %0t", checked_cnt, $realtime);
              $display("  exp rdata %h irq %b any %b lowest %0d drive %h enable %h",
                       want.rdata, want.irq, want.any, want.lowest, want.drive, want.enable);
              $display("  got rdata %h irq %b any %b lowest %0d drive %h enable %h",
                       seen.rdata, seen.irq, seen.any, seen.lowest, seen.drive, seen.enable);
            end
          end
        end
      end
      // long hold-off fills the output and skid stages so the input stalls
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (sent_cnt >= stim_q.size() - TAIL_ITEMS) begin
        out_stall <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("gpio_port_with_edge_interrupts_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < 2; k++) begin
      pad_sample[k] = '0;
      pad_prev[k] = '0;
      drive_latch[k] = '0;
      drive_en[k] = '0;
      irq_en[k] = '0;
      edge_mode[k] = '0;
      pol_hi[k] = '0;
      pol_lo[k] = '0;
      pend[k] = '0;
    end
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_cnt < stim_q.size()) @(posedge clk);
    while (port_status_q.size() != 0) @(posedge clk);
    // keep clocking to catch any stray result
    repeat (8) @(posedge clk);
    $display("covered %0d items (%0d reads, %0d writes, %0d pad samples), %0d results checked",
             sent_cnt, n_read, n_write, n_tick, checked_cnt);
    $display("interrupt line seen high in %0d results, %0d mismatches", irq_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("gpio_port_with_edge_interrupts_unit verification clean");
    end else begin
      $display("gpio_port_with_edge_interrupts_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gpio_pkg.sv
rtl/gpio_bank.sv
rtl/gpio_port_with_edge_interrupts_unit.sv
tb/gpio_port_with_edge_interrupts_unit_tb.sv
